### hdl/mclp_pkg.sv
// Package with the shared widths, codes and state encoding of the linear partition block.
package mclp_pkg;
   localparam int OP_W     = 1;
   localparam int ENTRY_W  = 24;
   localparam int STATUS_W = 2;
   localparam int COST_W   = 40;
   localparam int CSR_W    = 5;
   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 1'b0,
      OP_COMPUTE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_BUF   = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_JREAD  = 10'b0000000010,
      S_JWAIT  = 10'b0000000100,
      S_KREAD  = 10'b0000001000,
      S_KMUL   = 10'b0000010000,
      S_KADD   = 10'b0000100000,
      S_JWRITE = 10'b0001000000,
      S_FREAD  = 10'b0010000000,
      S_FWAIT  = 10'b0100000000,
      S_EMIT   = 10'b1000000000
   } state_type;
endpackage

### hdl/mclp_if.sv
// Handshake interfaces for the request and response channels.
interface mclp_req_if;
   logic                         valid;
   logic                         ready;
   logic [mclp_pkg::OP_W-1:0]    op;
   logic [mclp_pkg::ENTRY_W-1:0] entry_value;
   modport source (output valid, output op, output entry_value, input ready);
   modport sink (input valid, input op, input entry_value, output ready);
endinterface

interface mclp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mclp_pkg::STATUS_W-1:0] status;
   logic [mclp_pkg::COST_W-1:0]   min_cost;
   modport source (output valid, output status, output min_cost, input ready);
   modport sink (input valid, input status, input min_cost, output ready);
endinterface

### hdl/min_cost_linear_partition.sv
// Top level of the minimum-cost linear partition block.
//
// Usage: load items (op load) append one histogram entry each and are taken
// one per cycle while the block is idle. A compute item finds the least total
// cost of splitting the stored entries into at most csr_wr_data groups, where
// a group costs its sum times its length, and returns one response; the
// histogram is then empty again. Loads produce no response.
// Entries beyond MAX_ENTRIES are dropped and the next response has status 2.
// A buffer count of zero gives status 1 and cost zero, also after an overflow.
// A compute item fills one row per group r below the group count G, one end
// index j from r to n-1 at a time (row 0 with the single split at entry 0),
// then reads out the last row and emits. Each inner step is one prefix-sum
// read, one multiply and one add-compare, sequenced around the prefix and row
// memories.
// req.ready is low from a compute transfer until its response is registered.
// A stalled response sits in the output register; loads are still taken.
// Reset empties the histogram and sets the buffer count to 1; no clearing
// pass is needed.
module min_cost_linear_partition #(
   parameter int MAX_ENTRIES = 64,
   parameter int MAX_BUFFERS = 16,
   parameter int VALUE_BITS  = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   mclp_req_if.sink                   req,
   mclp_rsp_if.source                 rsp,
   input  logic                       csr_wr_en,
   input  logic [mclp_pkg::CSR_W-1:0] csr_wr_data
);
   import mclp_pkg::*;

   localparam int VB  = (VALUE_BITS < ENTRY_W) ? VALUE_BITS : ENTRY_W;
   localparam int IW  = $clog2(MAX_ENTRIES + 1);
   localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int SW  = VB + IW;
   localparam int CW  = SW + IW;
   localparam int XW  = (CW > COST_W) ? CW : COST_W;
   localparam int LW  = (IW > 7) ? IW : 7;
   localparam logic [LW-1:0] MAXB = LW'(MAX_BUFFERS);
   localparam logic [IW-1:0] MAXE = IW'(MAX_ENTRIES);

   state_type              state_ff, state_in;
   logic [CSR_W-1:0]       bufcnt_ff;
   logic [IW-1:0]          count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [SW-1:0]          sum_ff, sum_in;
   logic [IW-1:0]          n_ff, n_in;
   logic [IW-1:0]          groups_ff, groups_in;
   logic [IW-1:0]          r_ff, r_in;
   logic [IW-1:0]          j_ff, j_in;
   logic [IW-1:0]          k_ff, k_in;
   logic [SW-1:0]          pj_ff, pj_in;
   logic [CW-1:0]          prod_ff, prod_in;
   logic [CW-1:0]          prevc_ff, prevc_in;
   logic [CW-1:0]          best_ff, best_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [COST_W-1:0]      res_cost_ff, res_cost_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [COST_W-1:0]      rsp_cost_ff, rsp_cost_in;

   logic                   req_xfer, rsp_xfer, rsp_free;
   logic                   p_we;
   logic [IW-1:0]          p_waddr, p_raddr;
   logic [SW-1:0]          p_wdata, p_rdata;
   logic                   row_we0, row_we1;
   logic [AW-1:0]          row_waddr, row_raddr;
   logic [CW-1:0]          row_rdata0, row_rdata1, row_prev, row_last;
   logic [SW-1:0]          pk, diff;
   logic [IW-1:0]          len;
   logic [CW-1:0]          cand;
   logic [LW-1:0]          g_lim, n_ext;
   logic [XW-1:0]          cost_ext;

   mclp_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES + 1)) u_prefix_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   // Row banks alternate: row r writes bank r[0] and reads the other bank.
   mclp_ram #(.WIDTH(CW), .DEPTH(MAX_ENTRIES)) u_row0_ram (
      .clock   (clock),
      .wr_en   (row_we0),
      .wr_addr (row_waddr),
      .wr_data (best_ff),
      .rd_addr (row_raddr),
      .rd_data (row_rdata0)
   );

   mclp_ram #(.WIDTH(CW), .DEPTH(MAX_ENTRIES)) u_row1_ram (
      .clock   (clock),
      .wr_en   (row_we1),
      .wr_addr (row_waddr),
      .wr_data (best_ff),
      .rd_addr (row_raddr),
      .rd_data (row_rdata1)
   );

   assign req.ready    = (state_ff == S_IDLE);
   assign req_xfer     = req.valid && req.ready;
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.status   = rsp_status_ff;
   assign rsp.min_cost = rsp_cost_ff;
   assign rsp_xfer     = rsp_valid_ff && rsp.ready;
   assign rsp_free     = !rsp_valid_ff || rsp.ready;

   assign p_we      = req_xfer && (req.op == OP_LOAD) && (count_ff < MAXE);
   assign p_waddr   = count_ff + IW'(1);
   assign p_wdata   = sum_ff + SW'(req.entry_value[VB-1:0]);
   assign p_raddr   = (state_ff == S_JREAD) ? (j_ff + IW'(1)) : k_ff;

   assign row_waddr = j_ff[AW-1:0];
   assign row_we0   = (state_ff == S_JWRITE) && !r_ff[0];
   assign row_we1   = (state_ff == S_JWRITE) && r_ff[0];
   assign row_raddr = (state_ff == S_FREAD) ? n_ff[AW-1:0] - AW'(1)
                                            : k_ff[AW-1:0] - AW'(1);
   assign row_prev  = r_ff[0] ? row_rdata0 : row_rdata1;
   assign row_last  = r_ff[0] ? row_rdata1 : row_rdata0;

   assign pk   = (k_ff == '0) ? '0 : p_rdata;
   assign diff = pj_ff - pk;
   assign len  = j_ff - k_ff + IW'(1);
   assign cand = prod_ff + prevc_ff;

   assign n_ext    = LW'(count_ff);
   assign cost_ext = XW'(row_last);

   always_comb begin
      g_lim = LW'(bufcnt_ff);
      if (g_lim > MAXB) begin
         g_lim = MAXB;
      end
      if (g_lim > n_ext) begin
         g_lim = n_ext;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      sum_in        = sum_ff;
      n_in          = n_ff;
      groups_in     = groups_ff;
      r_in          = r_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      pj_in         = pj_ff;
      prod_in       = prod_ff;
      prevc_in      = prevc_ff;
      best_in       = best_ff;
      res_status_in = res_status_ff;
      res_cost_in   = res_cost_ff;
      rsp_valid_in  = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cost_in   = rsp_cost_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req.op == OP_LOAD)) begin
               if (count_ff < MAXE) begin
                  count_in = count_ff + IW'(1);
                  sum_in   = p_wdata;
               end else begin
                  ovf_in = 1'b1;
               end
            end else if (req_xfer) begin
               n_in        = count_ff;
               groups_in   = IW'(g_lim);
               r_in        = '0;
               j_in        = '0;
               res_cost_in = '0;
               count_in    = '0;
               ovf_in      = 1'b0;
               sum_in      = '0;
               if (bufcnt_ff == '0) begin
                  res_status_in = ST_NO_BUF;
                  state_in      = S_EMIT;
               end else begin
                  res_status_in = ovf_ff ? ST_OVERFLOW : ST_OK;
                  state_in      = (count_ff == '0) ? S_EMIT : S_JREAD;
               end
            end
         end
         S_JREAD: begin
            state_in = S_JWAIT;
         end
         S_JWAIT: begin
            pj_in    = p_rdata;
            best_in  = '1;
            k_in     = r_ff;
            state_in = S_KREAD;
         end
         S_KREAD: begin
            state_in = S_KMUL;
         end
         S_KMUL: begin
            prod_in  = CW'(diff) * CW'(len);
            prevc_in = (r_ff == '0) ? '0 : row_prev;
            state_in = S_KADD;
         end
         S_KADD: begin
            if (cand < best_ff) begin
               best_in = cand;
            end
            // In the first row the only group starts at entry 0.
            if ((k_ff == j_ff) || (r_ff == '0)) begin
               state_in = S_JWRITE;
            end else begin
               k_in     = k_ff + IW'(1);
               state_in = S_KREAD;
            end
         end
         S_JWRITE: begin
            if (j_ff == n_ff - IW'(1)) begin
               if (r_ff == groups_ff - IW'(1)) begin
                  state_in = S_FREAD;
               end else begin
                  r_in     = r_ff + IW'(1);
                  j_in     = r_ff + IW'(1);
                  state_in = S_JREAD;
               end
            end else begin
               j_in     = j_ff + IW'(1);
               state_in = S_JREAD;
            end
         end
         S_FREAD: begin
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            res_cost_in = (cost_ext > XW'(COST_MAX)) ? COST_MAX : cost_ext[COST_W-1:0];
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_cost_in   = res_cost_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bufcnt_ff    <= CSR_W'(1);
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            bufcnt_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      groups_ff     <= groups_in;
      r_ff          <= r_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      pj_ff         <= pj_in;
      prod_ff       <= prod_in;
      prevc_ff      <= prevc_in;
      best_ff       <= best_in;
      res_status_ff <= res_status_in;
      res_cost_ff   <= res_cost_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cost_ff   <= rsp_cost_in;
   end

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register is not one-hot");

   a_compute_clears: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req.op == OP_COMPUTE) |=> (count_ff == '0) && !ovf_ff)
      else $error("histogram not cleared after a compute transfer");

   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_KADD) |-> (k_ff <= j_ff) && (k_ff >= r_ff))
      else $error("split index outside its range");

   a_nobuf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && (rsp_status_ff == ST_NO_BUF) |-> (rsp_cost_ff == '0))
      else $error("nonzero cost with no buffers configured");
`endif
endmodule

### hdl/mclp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mclp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### test/tb_min_cost_linear_partition.sv
// Self-checking testbench for the minimum-cost linear partition block.
module tb_min_cost_linear_partition;
   timeunit 1ns;
   timeprecision 1ps;
   import mclp_pkg::*;

   localparam int HIST_DEPTH  = 64;
   localparam int GROUP_LIMIT = 16;
   localparam int RUN_ITEMS   = 1750;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_WAIT  = 20;
   localparam int HOLD_CYCLES = 2000;

   typedef struct {
      status_type        status;
      logic [COST_W-1:0] min_cost;
   } partition_result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   mclp_req_if req ();
   mclp_rsp_if rsp ();

   min_cost_linear_partition uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor state: the stored histogram, the overflow flag and the group limit.
   longint unsigned hist_entries[$];
   bit              hist_overflow;
   int              group_setting;
   partition_result_type pending_results[$];

   int error_count;
   int items_sent;
   int results_checked;
   int computes_sent;
   int burst_left;
   int stall_pct;
   bit hold_go;
   logic holding;
   longint cycle_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still expected",
                  cycle_count, pending_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Long receiver hold-off, counted here in cycles.
   always begin
      wait (hold_go);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      holding <= 1'b0;
      hold_go = 1'b0;
   end

   always @(posedge clock) begin
      if (holding)
         rsp.ready <= 1'b0;
      else
         rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic report(input string what, input longint unsigned got,
                         input longint unsigned want);
      $display("Mismatch in %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   // Ready is set at the clock edge, so its value at the falling edge is the one seen
   // by the next rising edge, where the transfer takes place.
   always @(negedge clock) begin
      partition_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            $display("Response with no expectation: status %0d cost %0d",
                     rsp.status, rsp.min_cost);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp.status !== want.status)
               report("status", rsp.status, want.status);
            if (rsp.min_cost !== want.min_cost)
               report("min_cost", rsp.min_cost, want.min_cost);
            results_checked++;
         end
      end
   end

   function automatic longint unsigned best_partition(input longint unsigned vals[$],
                                                      input int groups);
      longint unsigned sums[HIST_DEPTH+1];
      longint unsigned prev_row[HIST_DEPTH];
      longint unsigned cur_row[HIST_DEPTH];
      longint unsigned best, cand;
      int n;
      n = vals.size();
      sums[0] = 0;
      for (int i = 0; i < n; i++)
         sums[i+1] = sums[i] + vals[i];
      for (int j = 0; j < n; j++)
         prev_row[j] = sums[j+1] * (j + 1);
      for (int r = 1; r < groups; r++) begin
         for (int j = r; j < n; j++) begin
            best = '1;
            for (int k = r; k <= j; k++) begin
               cand = prev_row[k-1] + (sums[j+1] - sums[k]) * (j - k + 1);
               if (cand < best)
                  best = cand;
            end
            cur_row[j] = best;
         end
         for (int j = r; j < n; j++)
            prev_row[j] = cur_row[j];
      end
      return prev_row[n-1];
   endfunction

   function automatic partition_result_type predict_compute();
      partition_result_type res;
      int groups;
      longint unsigned cost;
      res.status = ST_OK;
      res.min_cost = '0;
      if (group_setting == 0) begin
         res.status = ST_NO_BUF;
      end else begin
         if (hist_overflow)
            res.status = ST_OVERFLOW;
         if (hist_entries.size() > 0) begin
            groups = group_setting;
            if (groups > GROUP_LIMIT)
               groups = GROUP_LIMIT;
            if (groups > hist_entries.size())
               groups = hist_entries.size();
            cost = best_partition(hist_entries, groups);
            if (cost > COST_MAX)
               cost = COST_MAX;
            res.min_cost = cost[COST_W-1:0];
         end
      end
      hist_entries.delete();
      hist_overflow = 1'b0;
      return res;
   endfunction

   // Sends one item in bursts with random gaps; valid stays high if the caller sends again within the burst.
   task automatic send_item(input op_type op, input logic [ENTRY_W-1:0] value);
      bit taken;
      if (burst_left == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req.valid <= 1'b1;
      req.op <= op;
      req.entry_value <= value;
      do begin
         @(negedge clock);
         taken = req.ready;
         @(posedge clock);
      end while (!taken);
      items_sent++;
      if (op == OP_LOAD) begin
         if (hist_entries.size() < HIST_DEPTH)
            hist_entries.push_back(value);
         else
            hist_overflow = 1'b1;
      end else begin
         pending_results.push_back(predict_compute());
         computes_sent++;
      end
   endtask

   task automatic wait_results();
      req.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_group_limit(input int value);
      wait_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[CSR_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      group_setting = value;
   endtask

   task automatic send_histogram(input int n, input bit full_range);
      for (int i = 0; i < n; i++)
         send_item(OP_LOAD, full_range ? ENTRY_W'($urandom())
                                       : ENTRY_W'($urandom_range(0, 255)));
      send_item(OP_COMPUTE, ENTRY_W'($urandom()));
   endtask

   task automatic test_directed();
      stall_pct = 0;
      send_item(OP_COMPUTE, '0);               // empty histogram at reset setting
      send_item(OP_LOAD, '0);
      send_item(OP_LOAD, '1);
      send_item(OP_COMPUTE, '1);
      write_group_limit(0);                     // no buffers
      send_item(OP_LOAD, 24'h000005);
      send_item(OP_LOAD, 24'h800000);
      send_item(OP_COMPUTE, '0);
      write_group_limit(16);                    // more groups than entries
      send_item(OP_LOAD, 24'h000001);
      send_item(OP_LOAD, 24'hFFFFFF);
      send_item(OP_LOAD, 24'h555555);
      send_item(OP_LOAD, 24'hAAAAAA);
      send_item(OP_COMPUTE, '0);
      send_item(OP_COMPUTE, '0);
      write_group_limit(31);                    // saturates to the group limit
      send_histogram(20, 1'b1);
   endtask

   task automatic test_overflow();
      write_group_limit(1);
      send_histogram(HIST_DEPTH + 3, 1'b1);
      write_group_limit(0);                     // no buffers wins over overflow
      send_histogram(HIST_DEPTH + 1, 1'b1);
      write_group_limit(GROUP_LIMIT);           // full store, full group count
      for (int i = 0; i < HIST_DEPTH; i++)
         send_item(OP_LOAD, '1);
      send_item(OP_COMPUTE, '0);
   endtask

   task automatic test_backpressure();
      write_group_limit(3);
      stall_pct = 0;
      hold_go = 1'b1;
      send_histogram(6, 1'b1);
      send_histogram(5, 1'b1);
      send_histogram(4, 1'b0);
      wait_results();
   endtask

   task automatic test_random();
      int n, pick, setting;
      while (items_sent < RUN_ITEMS) begin
         if ($urandom_range(0, 29) == 0) begin
            pick = $urandom_range(0, 9);
            setting = (pick == 0) ? 0 : (pick == 1) ? 31 : (pick == 2) ? 16 :
                      (pick == 3) ? 1 : $urandom_range(0, 31);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 70);
            write_group_limit(setting);
         end
         pick = $urandom_range(0, 99);
         if (pick < 70)
            n = $urandom_range(0, 8);
         else if (pick < 97)
            n = $urandom_range(9, 20);
         else
            n = $urandom_range(21, HIST_DEPTH + 6);
         if ($urandom_range(0, 9) == 0)
            send_item(OP_COMPUTE, ENTRY_W'($urandom()));  // stray compute
         send_histogram(n, $urandom_range(0, 2) != 0);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req.valid = 1'b0;
      req.op = OP_LOAD;
      req.entry_value = '0;
      rsp.ready = 1'b0;
      holding = 1'b0;
      hold_go = 1'b0;
      cycle_count = 0;
      error_count = 0;
      items_sent = 0;
      results_checked = 0;
      computes_sent = 0;
      burst_left = 0;
      stall_pct = 0;
      group_setting = 1;
      hist_overflow = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_backpressure();
      test_random();
      wait_results();
      $display("Sent %0d items (%0d computes), checked %0d results", items_sent,
               computes_sent, results_checked);
      $display("Covered empty, overflow, no-buffer and saturated group settings with stalls");
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

### min_cost_linear_partition.f
hdl/mclp_pkg.sv
hdl/mclp_if.sv
hdl/mclp_ram.sv
hdl/min_cost_linear_partition.sv
test/tb_min_cost_linear_partition.sv
